// File: rtl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants for the LRU key cache table.
// ----------------------------------------------------------------------------
package lkc_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	// fixed field widths of the request and response words
	localparam int URL_KEY_W = 32;
	localparam int HIT_POS_W = 4;
	localparam int SLOT_W    = 4;
	localparam int EVKEY_W   = 32;
	localparam int OCC_W     = 5;

	typedef enum logic [0:0] {
		S_IDLE,
		S_UPD
	} lkc_state_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;   // latch match against incoming key
		logic upd;   // commit shift / load
		logic hit;   // request hit a valid entry
		logic full;  // table holds ENTRIES valid entries
	} lkc_cell_ctl_t;

endpackage

// File: rtl/lkc_req_if.sv
// ----------------------------------------------------------------------------
// lkc_req_if
// Request channel: one hashed URL key per word.
// ----------------------------------------------------------------------------
interface lkc_req_if
	import lkc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [URL_KEY_W-1:0] url_key;

	modport source (output valid, output url_key, input ready);
	modport sink   (input valid, input url_key, output ready);
endinterface

// File: rtl/lkc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkc_rsp_if
// Response channel: lookup outcome per request word.
// ----------------------------------------------------------------------------
interface lkc_rsp_if
	import lkc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [HIT_POS_W-1:0] hit_position;
	logic [SLOT_W-1:0]    slot_handle;
	logic                 evicted;
	logic [EVKEY_W-1:0]   evicted_key;
	logic [OCC_W-1:0]     occupancy;

	modport source (output valid, output hit, output hit_position, output slot_handle,
		output evicted, output evicted_key, output occupancy, input ready);
	modport sink   (input valid, input hit, input hit_position, input slot_handle,
		input evicted, input evicted_key, input occupancy, output ready);
endinterface

// File: rtl/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell
// One recency position: stored key, slot handle, valid mark and match flag.
// ----------------------------------------------------------------------------
module lkc_cell
	import lkc_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int IDX      = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lkc_cell_ctl_t                    ctl,
	input  logic [KEY_BITS-1:0]              cmp_key,
	input  logic [KEY_BITS-1:0]              new_key,
	input  logic [$clog2(ENTRIES)-1:0]       new_slot,
	input  logic [$clog2(ENTRIES)-1:0]       pos,
	input  logic [$clog2(ENTRIES+1)-1:0]     count,
	input  logic [KEY_BITS-1:0]              nb_key,
	input  logic [$clog2(ENTRIES)-1:0]       nb_slot,
	output logic [KEY_BITS-1:0]              key,
	output logic [$clog2(ENTRIES)-1:0]       slot,
	output logic                             valid,
	output logic                             match
);
	localparam int CNT_W  = $clog2(ENTRIES+1);
	localparam int SW     = $clog2(ENTRIES);
	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);
	localparam bit TOP_CELL = (IDX == ENTRIES - 1);

	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0]       slot_q;
	logic                valid_q;
	logic                match_q;
	logic                is_last;
	logic                at_or_above;
	logic                shift_en;
	logic                load_en;
	logic                append_en;

	always_comb begin
		is_last     = (NEXT_C == count);
		at_or_above = (IDX_C >= CNT_W'(pos));
		append_en   = ctl.upd && !ctl.hit && !ctl.full && (IDX_C == count);
		if (ctl.hit) begin
			shift_en = ctl.upd && at_or_above && !is_last;
			load_en  = ctl.upd && is_last;
		end else begin
			shift_en = ctl.upd && ctl.full && !TOP_CELL;
			load_en  = (ctl.upd && ctl.full && TOP_CELL) || append_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (append_en) begin
				valid_q <= 1'b1;
			end
			if (ctl.cmp) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q  <= nb_key;
			slot_q <= nb_slot;
		end else if (load_en) begin
			key_q  <= new_key;
			slot_q <= new_slot;
		end
	end

	assign key   = key_q;
	assign slot  = slot_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

// File: rtl/lru_key_cache_table_core.sv
// ----------------------------------------------------------------------------
// lru_key_cache_table_core
// LRU-ordered key table built as a row of cells; position 0 is least recent.
// ----------------------------------------------------------------------------
// Operation: the cycle that accepts a request word compares its key in all
//   cells at once; the update state then shifts/loads the cell row and writes
//   the result. A new request word is taken only after the update is done.
//   The update waits while an earlier result word is still not taken.
// Reset: valid marks and entry count clear at once; stored keys and slots
//   are not reset and are never matched until written.
module lru_key_cache_table_core
	import lkc_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lkc_req_if.sink   req,
	lkc_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int SW    = $clog2(ENTRIES);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(ENTRIES);

	lkc_state_t          state_q, state_d;
	lkc_cell_ctl_t       ctl;
	logic [KEY_BITS-1:0] in_key;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;
	logic                commit;

	logic [KEY_BITS-1:0] cell_key   [ENTRIES];
	logic [SW-1:0]       cell_slot  [ENTRIES];
	logic [ENTRIES-1:0]  cell_valid;
	logic [ENTRIES-1:0]  cell_match;

	logic                hit;
	logic [SW-1:0]       hit_pos;
	logic [SW-1:0]       hit_slot;
	logic [SW-1:0]       new_slot;
	logic                full;
	logic                evict;
	logic [CNT_W-1:0]    count_next;

	logic                out_valid_q;
	logic                hit_q;
	logic [HIT_POS_W-1:0] hit_position_q;
	logic [SLOT_W-1:0]   slot_handle_q;
	logic                evicted_q;
	logic [EVKEY_W-1:0]  evicted_key_q;
	logic [OCC_W-1:0]    occupancy_q;

	logic [KEY_BITS+URL_KEY_W-1:0] key_ext;
	logic [SW+SLOT_W-1:0]          slot_ext;
	logic [SW+HIT_POS_W-1:0]       pos_ext;
	logic [KEY_BITS+EVKEY_W-1:0]   evk_ext;
	logic [CNT_W+OCC_W-1:0]        occ_ext;

	// request key trimmed or widened to table key width
	assign key_ext = {{KEY_BITS{1'b0}}, req.url_key};
	assign in_key  = key_ext[KEY_BITS-1:0];

	// one-hot match reduction; valid keys are unique so at most one bit is set
	always_comb begin
		hit      = |cell_match;
		hit_pos  = '0;
		hit_slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_pos  = hit_pos  | (cell_match[i] ? SW'(i) : '0);
			hit_slot = hit_slot | (cell_match[i] ? cell_slot[i] : '0);
		end
	end

	always_comb begin
		full  = (count_q == FULL_C);
		evict = !hit && full;
		if (hit) begin
			new_slot = hit_slot;
		end else if (full) begin
			new_slot = cell_slot[0];
		end else begin
			new_slot = count_q[SW-1:0];
		end
		count_next = (!hit && !full) ? count_q + 1'b1 : count_q;
	end

	always_comb begin
		state_d   = state_q;
		commit    = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				// hold the match flags until the result register frees up
				if (!out_valid_q || rsp.ready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.cmp  = req.valid && req.ready;
		ctl.upd  = commit;
		ctl.hit  = hit;
		ctl.full = full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, new_slot};
	assign pos_ext  = {{HIT_POS_W{1'b0}}, hit_pos};
	assign evk_ext  = {{EVKEY_W{1'b0}}, cell_key[0]};
	assign occ_ext  = {{OCC_W{1'b0}}, count_next};

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			key_q <= in_key;
		end
		if (commit) begin
			hit_q          <= hit;
			hit_position_q <= pos_ext[HIT_POS_W-1:0];
			slot_handle_q  <= slot_ext[SLOT_W-1:0];
			evicted_q      <= evict;
			evicted_key_q  <= evict ? evk_ext[EVKEY_W-1:0] : '0;
			occupancy_q    <= occ_ext[OCC_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.hit_position = hit_position_q;
	assign rsp.slot_handle  = slot_handle_q;
	assign rsp.evicted      = evicted_q;
	assign rsp.evicted_key  = evicted_key_q;
	assign rsp.occupancy    = occupancy_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic [KEY_BITS-1:0] nb_key;
		logic [SW-1:0]       nb_slot;

		if (g < ENTRIES - 1) begin : g_nb
			assign nb_key  = cell_key[g+1];
			assign nb_slot = cell_slot[g+1];
		end else begin : g_top
			assign nb_key  = '0;
			assign nb_slot = '0;
		end

		lkc_cell #(
			.ENTRIES  (ENTRIES),
			.KEY_BITS (KEY_BITS),
			.IDX      (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cmp_key  (in_key),
			.new_key  (key_q),
			.new_slot (new_slot),
			.pos      (hit_pos),
			.count    (count_q),
			.nb_key   (nb_key),
			.nb_slot  (nb_slot),
			.key      (cell_key[g]),
			.slot     (cell_slot[g]),
			.valid    (cell_valid[g]),
			.match    (cell_match[g])
		);
	end

	// valid marks form a prefix of length count_q; unused outside the cells
	logic unused_valid;
	assign unused_valid = ^cell_valid;

endmodule
